// File: rtl/core/npta_pkg.sv
// Package for the node presence table: request and response payload types,
// operation and status codes, and the name normalization function.
// Depends on nothing; used by the top level and the checker.
package npta_pkg;

  localparam int NAME_W        = 64;
  localparam int NAME_CHARS    = 8;
  localparam int MAC_W         = 48;
  localparam int TIME_W        = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_INDEX_W = 4;
  localparam int COUNT_W       = 5;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

  typedef enum logic [OP_W-1:0] {
    OP_SEEN       = 3'd0,
    OP_SET_TYPE   = 3'd1,
    OP_SWEEP      = 3'd2,
    OP_QUERY_TYPE = 3'd3,
    OP_LOOKUP     = 3'd4
  } op_e;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [NAME_W-1:0] node_key;
    logic [MAC_W-1:0]  mac_address;
    logic [NAME_W-1:0] type_name;
    logic [TIME_W-1:0] now_ms;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     hit;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic                     entry_online;
    logic [MAC_W-1:0]         entry_mac;
    logic [NAME_W-1:0]        entry_type;
    logic [COUNT_W-1:0]       online_count;
    logic                     newly_online;
    logic [COUNT_W-1:0]       went_offline;
  } out_rsp_t;

  // A name ends at its first zero byte; later bytes and bytes past chars are cleared.
  function automatic logic [NAME_W-1:0] norm_name(logic [NAME_W-1:0] v, int chars);
    logic [NAME_W-1:0] r;
    logic              alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (i >= chars || v[8*i +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        r[8*i +: 8] = v[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/npta_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the entry stores of the node presence table.
module npta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/node_presence_table_aging.sv
// Node presence table with aging timeout: top level with its sequencer.
// Depends on npta_pkg and npta_ram.
//
// Requests enter on in_valid/in_ready with an npta_pkg::in_req_t payload and
// one response leaves per request on out_valid/out_ready as npta_pkg::out_rsp_t.
// The timeout register is written with cfg_we/cfg_wdata in any cycle.
// A request is handled by one scan over the used entries: the entry stores are
// RAMs read one address per cycle through their registered read port, and one
// comparator stage checks key, type or age for the entry just read.
// A request's scan ends at the first key or type match, or else once every used
// entry has been read; an undefined operation skips the scan and goes straight
// to the final step. in_ready is high only while the sequencer is idle, so the
// next request is accepted only after the previous response is produced.
// The response sits in an output register; a stalled receiver holds it there
// while the next request is accepted and scanned, and the sequencer then waits
// in its final step until the register is free.
// Reset clears the entry count, the online marks and count, and loads the
// timeout with 30000 ms. The RAM contents need no clearing pass.
module node_presence_table_aging #(
  parameter int TABLE_ENTRIES = 16,
  parameter int KEY_CHARS     = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  npta_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output npta_pkg::out_rsp_t              out_data,
  input  logic                            cfg_we,
  input  logic [npta_pkg::TIME_W-1:0]     cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                        state;
  logic [npta_pkg::TIME_W-1:0]   timeout_ms;
  logic [CNT_W-1:0]              used_entries;
  logic [CNT_W-1:0]              online_total;
  logic [TABLE_ENTRIES-1:0]      online_marks;

  npta_pkg::op_e                 req_op;
  logic [npta_pkg::NAME_W-1:0]   req_key;
  logic [npta_pkg::MAC_W-1:0]    req_mac;
  logic [npta_pkg::NAME_W-1:0]   req_type;
  logic [npta_pkg::TIME_W-1:0]   req_now;

  logic [CNT_W-1:0]              ptr;
  logic                          rd_pend;
  logic [IDX_W-1:0]              rd_idx;
  logic                          found;
  logic [IDX_W-1:0]              found_idx;
  logic [npta_pkg::MAC_W-1:0]    cap_mac;
  logic [npta_pkg::NAME_W-1:0]   cap_type;
  logic [CNT_W-1:0]              gone;

  logic [npta_pkg::NAME_W-1:0]   key_rdata;
  logic [npta_pkg::MAC_W-1:0]    mac_rdata;
  logic [npta_pkg::NAME_W-1:0]   type_rdata;
  logic [npta_pkg::TIME_W-1:0]   seen_rdata;

  logic                          scan_issue;
  logic                          key_match;
  logic                          type_match;
  logic                          aged;
  logic                          scan_hit;
  logic [npta_pkg::TIME_W-1:0]   elapsed;

  logic                          fin_go;
  logic [IDX_W-1:0]              wr_idx;
  logic                          key_we;
  logic                          mac_we;
  logic                          type_we;
  logic                          seen_we;
  logic [npta_pkg::NAME_W-1:0]   type_wdata;
  logic                          set_mark;
  logic [CNT_W-1:0]              total_next;
  logic [CNT_W-1:0]              used_next;
  npta_pkg::out_rsp_t            rsp;

  assign in_ready   = (state == ST_IDLE);
  assign scan_issue = (state == ST_SCAN) && (ptr < used_entries);
  assign elapsed    = req_now - seen_rdata;
  assign key_match  = rd_pend && (key_rdata == req_key);
  assign type_match = rd_pend && online_marks[rd_idx] && (type_rdata == req_type);
  assign aged       = rd_pend && online_marks[rd_idx] && (elapsed > timeout_ms);
  assign fin_go     = (state == ST_FINISH) && (!out_valid || out_ready);

  always_comb begin
    unique case (req_op)
      npta_pkg::OP_SEEN, npta_pkg::OP_SET_TYPE, npta_pkg::OP_LOOKUP: scan_hit = key_match;
      npta_pkg::OP_QUERY_TYPE: scan_hit = type_match;
      default: scan_hit = 1'b0;
    endcase
  end

  npta_ram #(.WIDTH(npta_pkg::NAME_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (fin_go && key_we),
    .waddr (wr_idx),
    .wdata (req_key),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  npta_ram #(.WIDTH(npta_pkg::MAC_W), .DEPTH(TABLE_ENTRIES)) u_mac_ram (
    .clk   (clk),
    .we    (fin_go && mac_we),
    .waddr (wr_idx),
    .wdata (req_mac),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (mac_rdata)
  );

  npta_ram #(.WIDTH(npta_pkg::NAME_W), .DEPTH(TABLE_ENTRIES)) u_type_ram (
    .clk   (clk),
    .we    (fin_go && type_we),
    .waddr (wr_idx),
    .wdata (type_wdata),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (type_rdata)
  );

  npta_ram #(.WIDTH(npta_pkg::TIME_W), .DEPTH(TABLE_ENTRIES)) u_seen_ram (
    .clk   (clk),
    .we    (fin_go && seen_we),
    .waddr (wr_idx),
    .wdata (req_now),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (seen_rdata)
  );

  always_comb begin
    rsp        = '0;
    wr_idx     = found_idx;
    key_we     = 1'b0;
    mac_we     = 1'b0;
    type_we    = 1'b0;
    seen_we    = 1'b0;
    type_wdata = req_type;
    set_mark   = 1'b0;
    total_next = online_total;
    used_next  = used_entries;
    unique case (req_op)
      npta_pkg::OP_SEEN: begin
        if (found) begin
          seen_we         = 1'b1;
          rsp.hit         = 1'b1;
          rsp.entry_mac   = cap_mac;
          rsp.entry_type  = cap_type;
        end else if (used_entries >= FULL_CNT) begin
          rsp.status = npta_pkg::STATUS_FULL;
        end else begin
          wr_idx        = used_entries[IDX_W-1:0];
          key_we        = 1'b1;
          mac_we        = 1'b1;
          type_we       = 1'b1;
          seen_we       = 1'b1;
          type_wdata    = '0;
          used_next     = used_entries + 1'b1;
          rsp.entry_mac = req_mac;
        end
        if (seen_we) begin
          rsp.entry_index  = npta_pkg::ENTRY_INDEX_W'(wr_idx);
          rsp.entry_online = 1'b1;
          if (!online_marks[wr_idx]) begin
            set_mark         = 1'b1;
            total_next       = online_total + 1'b1;
            rsp.newly_online = 1'b1;
          end
        end
      end
      npta_pkg::OP_SET_TYPE: begin
        if (found) begin
          type_we          = 1'b1;
          rsp.hit          = 1'b1;
          rsp.entry_index  = npta_pkg::ENTRY_INDEX_W'(found_idx);
          rsp.entry_online = online_marks[found_idx];
          rsp.entry_mac    = cap_mac;
          rsp.entry_type   = req_type;
        end else begin
          rsp.status = npta_pkg::STATUS_NOT_FOUND;
        end
      end
      npta_pkg::OP_SWEEP: begin
        total_next       = online_total - gone;
        rsp.went_offline = npta_pkg::COUNT_W'(gone);
      end
      npta_pkg::OP_QUERY_TYPE: begin
        rsp.hit = found;
      end
      npta_pkg::OP_LOOKUP: begin
        if (found) begin
          rsp.hit          = 1'b1;
          rsp.entry_index  = npta_pkg::ENTRY_INDEX_W'(found_idx);
          rsp.entry_online = online_marks[found_idx];
          rsp.entry_mac    = cap_mac;
          rsp.entry_type   = cap_type;
        end else begin
          rsp.status = npta_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    rsp.online_count = npta_pkg::COUNT_W'(total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      timeout_ms   <= npta_pkg::TIMEOUT_RESET;
      used_entries <= '0;
      online_total <= '0;
      online_marks <= '0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ms <= cfg_wdata;
      end
      if (out_valid && out_ready && !fin_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_op   <= npta_pkg::op_e'(in_data.op);
            req_key  <= npta_pkg::norm_name(in_data.node_key, KEY_CHARS);
            req_mac  <= in_data.mac_address;
            req_type <= npta_pkg::norm_name(in_data.type_name, npta_pkg::NAME_CHARS);
            req_now  <= in_data.now_ms;
            ptr      <= '0;
            rd_pend  <= 1'b0;
            found    <= 1'b0;
            gone     <= '0;
            if (in_data.op <= npta_pkg::OP_LOOKUP) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= scan_issue;
          rd_idx  <= ptr[IDX_W-1:0];
          if (scan_issue) begin
            ptr <= ptr + 1'b1;
          end
          if (aged && req_op == npta_pkg::OP_SWEEP) begin
            online_marks[rd_idx] <= 1'b0;
            gone                 <= gone + 1'b1;
          end
          if (scan_hit) begin
            found     <= 1'b1;
            found_idx <= rd_idx;
            cap_mac   <= mac_rdata;
            cap_type  <= type_rdata;
            state     <= ST_FINISH;
          end else if (!scan_issue) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_go) begin
            out_valid    <= 1'b1;
            out_data     <= rsp;
            used_entries <= used_next;
            online_total <= total_next;
            if (set_mark) begin
              online_marks[wr_idx] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/npta_checker.sv
// Port-level checks for the node presence table and the bind that attaches them.
// Depends on npta_pkg and on the node_presence_table_aging top level.
module npta_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input npta_pkg::out_rsp_t out_data
);

  // The block works on one request at a time.
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one was in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled response changed or dropped");

  // A failed request reports no hit, no new node and no aging.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != npta_pkg::STATUS_OK |->
      !out_data.hit && !out_data.newly_online && out_data.went_offline == '0)
    else $error("failed request carries result fields");

  a_newly_online: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.newly_online |->
      out_data.entry_online && out_data.went_offline == '0)
    else $error("newly online entry not reported online");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("response present right after reset");

endmodule

bind node_presence_table_aging npta_checker u_npta_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
